@@ src/ttb_pkg.sv @@
// Package for the triangle tangent and bitangent block: widths and shared types.
package ttb_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DW = WORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int SW = NW + FRAC_BITS;
    localparam int MW = 2 * WORD_BITS + 4;
    localparam int QDEPTH = 2;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [DW-1:0] delta_t;

    typedef struct packed {
        delta_t dp1_x;
        delta_t dp1_y;
        delta_t dp1_z;
        delta_t dp2_x;
        delta_t dp2_y;
        delta_t dp2_z;
        delta_t du1;
        delta_t dv1;
        delta_t du2;
        delta_t dv2;
    } tri_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } back_state_t;

endpackage

@@ src/ttb_front.sv @@
// Front part: holds the first two vertices and forms deltas on the third.
module ttb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ttb_pkg::word_t      s_pos_x,
    input  ttb_pkg::word_t      s_pos_y,
    input  ttb_pkg::word_t      s_pos_z,
    input  ttb_pkg::word_t      s_tex_u,
    input  ttb_pkg::word_t      s_tex_v,
    output logic                job_valid,
    input  logic                job_ready,
    output ttb_pkg::tri_job_t   job
);
    import ttb_pkg::*;

    logic [1:0] count_reg;
    word_t      p1_reg [3];
    word_t      p2_reg [3];
    word_t      t1_reg [2];
    word_t      t2_reg [2];
    logic       third;
    logic       take;

    function automatic delta_t dsub(input word_t a, input word_t b);
        return delta_t'(a) - delta_t'(b);
    endfunction

    assign third     = (count_reg == 2'd2);
    assign s_ready   = !third || job_ready;
    assign job_valid = s_valid && third;
    assign take      = s_valid && s_ready;

    always_comb begin
        job.dp1_x = dsub(p2_reg[0], p1_reg[0]);
        job.dp1_y = dsub(p2_reg[1], p1_reg[1]);
        job.dp1_z = dsub(p2_reg[2], p1_reg[2]);
        job.dp2_x = dsub(s_pos_x, p1_reg[0]);
        job.dp2_y = dsub(s_pos_y, p1_reg[1]);
        job.dp2_z = dsub(s_pos_z, p1_reg[2]);
        job.du1   = dsub(t2_reg[0], t1_reg[0]);
        job.dv1   = dsub(t2_reg[1], t1_reg[1]);
        job.du2   = dsub(s_tex_u, t1_reg[0]);
        job.dv2   = dsub(s_tex_v, t1_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (take) begin
            count_reg <= (count_reg == 2'd1) ? 2'd2 : (third ? 2'd0 : 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (take && count_reg == 2'd1) begin
            p2_reg[0] <= s_pos_x;
            p2_reg[1] <= s_pos_y;
            p2_reg[2] <= s_pos_z;
            t2_reg[0] <= s_tex_u;
            t2_reg[1] <= s_tex_v;
        end else if (take && !third) begin
            p1_reg[0] <= s_pos_x;
            p1_reg[1] <= s_pos_y;
            p1_reg[2] <= s_pos_z;
            t1_reg[0] <= s_tex_u;
            t1_reg[1] <= s_tex_v;
        end
    end

    count_never_three: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("vertex count out of range");
    job_only_on_third: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> third) else $error("job without third vertex");
    wraps_after_third: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && third) |=> count_reg == 2'd0) else $error("count did not wrap");

endmodule

@@ src/ttb_queue.sv @@
// Short job queue between the front and back parts.
module ttb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ttb_pkg::tri_job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output ttb_pkg::tri_job_t out_job
);
    import ttb_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    tri_job_t       mem_reg [QDEPTH];
    logic [AW-1:0]  wr_reg;
    logic [AW-1:0]  rd_reg;
    logic [AW:0]    cnt_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (cnt_reg < (AW+1)'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_job;
        end
    end

    no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(QDEPTH)) else $error("queue overflow");
    pop_only_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != '0) else $error("pop from empty queue");
    count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count slip");

endmodule

@@ src/ttb_back.sv @@
// Back part: shared multiplier and restoring divider for one triangle at a time.
module ttb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  ttb_pkg::tri_job_t job,
    output logic              m_valid,
    input  logic              m_ready,
    output ttb_pkg::word_t    m_tangent_x,
    output ttb_pkg::word_t    m_tangent_y,
    output ttb_pkg::word_t    m_tangent_z,
    output ttb_pkg::word_t    m_bitangent_x,
    output ttb_pkg::word_t    m_bitangent_y,
    output ttb_pkg::word_t    m_bitangent_z,
    output logic              m_degenerate
);
    import ttb_pkg::*;

    localparam int CW = $clog2(SW + 1);

    back_state_t state_reg, state_next;
    tri_job_t    job_reg;
    logic [3:0]  mstep_reg;
    logic [2:0]  comp_reg;
    logic [CW-1:0] bit_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [NW-1:0] acc_reg;
    logic signed [NW-1:0] num_reg [6];
    logic signed [NW-1:0] det_reg;
    logic [SW-1:0] n_reg;
    logic [SW:0]   r_reg;
    logic [SW-1:0] q_reg;
    word_t res_reg [6];
    logic  degen_reg;

    delta_t ma, mb;
    logic signed [PW-1:0] prod;
    logic [NW-1:0] dmag;
    logic [SW:0]   rshift;
    logic          rge;
    logic          neg;
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] mag;
    logic [SW-1:0] nmag;

    always_comb begin
        unique case (mstep_reg)
            4'd0:  begin ma = job_reg.du1;   mb = job_reg.dv2; end
            4'd1:  begin ma = job_reg.dv1;   mb = job_reg.du2; end
            4'd2:  begin ma = job_reg.dp1_x; mb = job_reg.dv2; end
            4'd3:  begin ma = job_reg.dp2_x; mb = job_reg.dv1; end
            4'd4:  begin ma = job_reg.dp1_y; mb = job_reg.dv2; end
            4'd5:  begin ma = job_reg.dp2_y; mb = job_reg.dv1; end
            4'd6:  begin ma = job_reg.dp1_z; mb = job_reg.dv2; end
            4'd7:  begin ma = job_reg.dp2_z; mb = job_reg.dv1; end
            4'd8:  begin ma = job_reg.dp2_x; mb = job_reg.du1; end
            4'd9:  begin ma = job_reg.dp1_x; mb = job_reg.du2; end
            4'd10: begin ma = job_reg.dp2_y; mb = job_reg.du1; end
            4'd11: begin ma = job_reg.dp1_y; mb = job_reg.du2; end
            4'd12: begin ma = job_reg.dp2_z; mb = job_reg.du1; end
            4'd13: begin ma = job_reg.dp1_z; mb = job_reg.du2; end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = PW'(ma) * PW'(mb);
    end

    assign dmag   = det_reg[NW-1] ? NW'(-det_reg) : NW'(det_reg);
    assign rshift = {r_reg[SW-1:0], n_reg[SW-1]};
    assign rge    = rshift >= (SW+1)'(dmag);
    assign neg    = num_reg[comp_reg][NW-1] ^ det_reg[NW-1];
    assign lim    = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    assign mag    = (q_reg[SW-1:WORD_BITS] != '0 || q_reg[WORD_BITS-1:0] > lim)
                    ? lim : q_reg[WORD_BITS-1:0];
    assign nmag   = {(num_reg[comp_reg][NW-1] ? NW'(-num_reg[comp_reg])
                                              : NW'(num_reg[comp_reg])),
                     {FRAC_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        job_ready  = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mstep_reg == 4'd14) begin
                    state_next = (det_reg == '0) ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (bit_reg == CW'(1)) state_next = ST_NEXT;
            end
            ST_NEXT: begin
                state_next = (comp_reg == 3'd5) ? ST_OUT : ST_DIV;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                job_reg   <= job;
                mstep_reg <= '0;
                degen_reg <= 1'b0;
            end
            ST_MUL: begin
                prod_reg  <= prod;
                mstep_reg <= mstep_reg + 1'b1;
                if (mstep_reg != 4'd0) begin
                    if (mstep_reg[0]) begin
                        acc_reg <= NW'(prod_reg);
                    end else begin
                        if (mstep_reg == 4'd2) det_reg <= acc_reg - NW'(prod_reg);
                        else num_reg[3'((mstep_reg - 4'd4) >> 1)] <= acc_reg - NW'(prod_reg);
                    end
                end
                if (mstep_reg == 4'd14) begin
                    comp_reg <= 3'd0;
                    bit_reg  <= CW'(SW);
                    r_reg    <= '0;
                    q_reg    <= '0;
                    if (det_reg == '0) begin
                        degen_reg <= 1'b1;
                        for (int k = 0; k < 6; k++) res_reg[k] <= '0;
                    end
                end
                if (mstep_reg == 4'd13) begin
                    n_reg <= '0;
                end
            end
            ST_DIV: begin
                if (bit_reg == CW'(SW)) begin
                    n_reg <= {nmag[SW-2:0], 1'b0};
                    r_reg <= (SW+1)'(nmag[SW-1]) >= (SW+1)'(dmag)
                             ? (SW+1)'(nmag[SW-1]) - (SW+1)'(dmag) : (SW+1)'(nmag[SW-1]);
                    q_reg <= SW'((SW+1)'(nmag[SW-1]) >= (SW+1)'(dmag));
                end else begin
                    n_reg <= {n_reg[SW-2:0], 1'b0};
                    r_reg <= rge ? rshift - (SW+1)'(dmag) : rshift;
                    q_reg <= {q_reg[SW-2:0], rge};
                end
                bit_reg <= bit_reg - 1'b1;
            end
            ST_NEXT: begin
                res_reg[comp_reg] <= neg ? word_t'(-mag) : word_t'(mag);
                comp_reg <= comp_reg + 1'b1;
                bit_reg  <= CW'(SW);
                r_reg    <= '0;
                q_reg    <= '0;
            end
            default: begin
            end
        endcase
    end

    assign m_tangent_x   = res_reg[0];
    assign m_tangent_y   = res_reg[1];
    assign m_tangent_z   = res_reg[2];
    assign m_bitangent_x = res_reg[3];
    assign m_bitangent_y = res_reg[4];
    assign m_bitangent_z = res_reg[5];
    assign m_degenerate  = degen_reg;

    degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> (m_tangent_x == '0 && m_bitangent_z == '0))
        else $error("degenerate result not zero");
    result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_tangent_x)))
        else $error("result changed while stalled");
    busy_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !job_ready) else $error("job taken while busy");

endmodule

@@ src/triangle_tangent_bitangent.sv @@
// Top level of the triangle tangent and bitangent block.
// Vertices stream in, three per triangle; each third vertex yields one transfer of
// tangent and bitangent (Q16.16, saturated) with a degenerate flag when the UV
// determinant is zero. In the back part a triangle passes an accept state, then
// the shared multiplier, then for each of the 6 components the one-bit-per-cycle
// restoring divider (83 quotient bits plus a store step each), then an output
// state; a degenerate triangle skips the divider. A two-entry queue lets vertices
// of following triangles in meanwhile, so the divider sets the sustained rate.
module triangle_tangent_bitangent (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ttb_pkg::word_t s_pos_x,
    input  ttb_pkg::word_t s_pos_y,
    input  ttb_pkg::word_t s_pos_z,
    input  ttb_pkg::word_t s_tex_u,
    input  ttb_pkg::word_t s_tex_v,
    output logic           m_valid,
    input  logic           m_ready,
    output ttb_pkg::word_t m_tangent_x,
    output ttb_pkg::word_t m_tangent_y,
    output ttb_pkg::word_t m_tangent_z,
    output ttb_pkg::word_t m_bitangent_x,
    output ttb_pkg::word_t m_bitangent_y,
    output ttb_pkg::word_t m_bitangent_z,
    output logic           m_degenerate
);
    import ttb_pkg::*;

    logic     fq_valid, fq_ready, qb_valid, qb_ready;
    tri_job_t fq_job, qb_job;

    ttb_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_pos_x, .s_pos_y, .s_pos_z, .s_tex_u, .s_tex_v,
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    ttb_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
    );

    ttb_back u_back (
        .aclk, .aresetn,
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .m_valid, .m_ready,
        .m_tangent_x, .m_tangent_y, .m_tangent_z,
        .m_bitangent_x, .m_bitangent_y, .m_bitangent_z, .m_degenerate
    );

endmodule
